[rtl/cbb_pkg.sv]
package cbb_pkg;

    // Unit vectors are signed Q2.30
    localparam int UNIT_BITS = 30;
    localparam int SQ_STEPS  = 32;  // one root bit per stage
    localparam int DIV_STEPS = 31;  // one quotient bit per stage

    localparam logic [31:0] UNIT_ONE = 32'd1 << UNIT_BITS;

    // Configuration register indexes
    localparam logic [1:0] CFG_BOUNDS_SCALE = 2'd0;
    localparam logic [1:0] CFG_PAD_FRACTION = 2'd1;
    localparam logic [1:0] CFG_MIN_PAD      = 2'd2;

    localparam logic [16:0] BOUNDS_SCALE_RST = 17'd72090;
    localparam logic [15:0] PAD_FRACTION_RST = 16'd3932;
    localparam logic [15:0] MIN_PAD_RST      = 16'd66;

    typedef logic signed [31:0] t_coord;
    typedef t_coord [2:0] t_vec;
    typedef logic [5:0][31:0] t_bounds;

    // Words that ride along the normalize pipelines
    typedef struct packed {
        t_vec   ctr;
        t_coord rad;
        t_coord len;
        t_vec   a;
        t_vec   u;
    } t_side;

    // Clamp to signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [37:0] x);
        logic [31:0] r;
        if (x > 38'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (x < -38'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/cbb_norm.sv]
module cbb_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cbb_pkg::t_vec  i_vec,
    input  cbb_pkg::t_side i_side,
    output logic          o_valid,
    output cbb_pkg::t_vec  o_vec,
    output logic          o_zero,
    output cbb_pkg::t_side o_side
);
    import cbb_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] m;
        logic [2:0]       neg;
        t_side            side;
    } t_ncarry;

    // Magnitudes and squares
    logic             r_a_vld;
    t_ncarry          r_a_c, n_a_c;
    logic [2:0][63:0] r_a_sq, n_a_sq;

    always_comb begin
        n_a_c.side = i_side;
        for (int i = 0; i < 3; i++) begin
            n_a_c.neg[i] = i_vec[i][31];
            n_a_c.m[i]   = i_vec[i][31] ? 32'(-i_vec[i]) : 32'(i_vec[i]);
            n_a_sq[i]    = 64'(n_a_c.m[i]) * 64'(n_a_c.m[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_c  <= n_a_c;
            r_a_sq <= n_a_sq;
        end
    end

    // Square root, one result bit per stage; entry 0 holds the sum of squares
    logic [63:0] r_rt_n   [0:SQ_STEPS];
    logic [63:0] r_rt_res [0:SQ_STEPS];
    t_ncarry     r_rt_c   [0:SQ_STEPS];
    logic        r_rt_vld [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_rt_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rt_n[0]   <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_rt_res[0] <= '0;
            r_rt_c[0]   <= r_a_c;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BITC = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = r_rt_res[k] + BITC;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_rt_vld[k+1] <= r_rt_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rt_c[k+1] <= r_rt_c[k];
                if (r_rt_n[k] >= trial) begin
                    r_rt_n[k+1]   <= r_rt_n[k] - trial;
                    r_rt_res[k+1] <= (r_rt_res[k] >> 1) + BITC;
                end else begin
                    r_rt_n[k+1]   <= r_rt_n[k];
                    r_rt_res[k+1] <= r_rt_res[k] >> 1;
                end
            end
        end
    end

    // Divide (m << 30 + n/2) by n, one quotient bit per stage
    logic [2:0][31:0] r_dv_rem [0:DIV_STEPS];
    logic [2:0][30:0] r_dv_low [0:DIV_STEPS];
    logic [2:0][30:0] r_dv_q   [0:DIV_STEPS];
    logic [31:0]      r_dv_n   [0:DIV_STEPS];
    logic             r_dv_z   [0:DIV_STEPS];
    t_ncarry          r_dv_c   [0:DIV_STEPS];
    logic             r_dv_vld [0:DIV_STEPS];

    logic [31:0]      root;
    logic [2:0][61:0] num;

    always_comb begin
        root = r_rt_res[SQ_STEPS][31:0];
        for (int i = 0; i < 3; i++) begin
            num[i] = {r_rt_c[SQ_STEPS].m[i], 30'd0} + 62'(root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_vld[0] <= r_rt_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_n[0] <= root;
            r_dv_z[0] <= (root == 32'd0);
            r_dv_c[0] <= r_rt_c[SQ_STEPS];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= {1'b0, num[i][61:31]};
                r_dv_low[0][i] <= num[i][30:0];
                r_dv_q[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [2:0][32:0] cat;
        logic [2:0]       ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cat[i] = {r_dv_rem[j][i], r_dv_low[j][i][DIV_STEPS-1-j]};
                ge[i]  = cat[i] >= {1'b0, r_dv_n[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_n[j+1]   <= r_dv_n[j];
                r_dv_z[j+1]   <= r_dv_z[j];
                r_dv_c[j+1]   <= r_dv_c[j];
                r_dv_low[j+1] <= r_dv_low[j];
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j+1][i] <= ge[i] ? 32'(cat[i] - {1'b0, r_dv_n[j]})
                                              : cat[i][31:0];
                    r_dv_q[j+1][i]   <= {r_dv_q[j][i][29:0], ge[i]};
                end
            end
        end
    end

    // Sign back on; zero vector gives zeros
    logic  r_o_vld;
    t_vec  r_o_vec;
    logic  r_o_z;
    t_side r_o_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_dv_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_z    <= r_dv_z[DIV_STEPS];
            r_o_side <= r_dv_c[DIV_STEPS].side;
            for (int i = 0; i < 3; i++) begin
                if (r_dv_z[DIV_STEPS]) begin
                    r_o_vec[i] <= '0;
                end else if (r_dv_c[DIV_STEPS].neg[i]) begin
                    r_o_vec[i] <= -$signed({1'b0, r_dv_q[DIV_STEPS][i]});
                end else begin
                    r_o_vec[i] <= $signed({1'b0, r_dv_q[DIV_STEPS][i]});
                end
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_vec   = r_o_vec;
    assign o_zero  = r_o_z;
    assign o_side  = r_o_side;

endmodule

[rtl/cbb_cross.sv]
module cbb_cross (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cbb_pkg::t_vec  i_u,
    input  cbb_pkg::t_side i_side,
    output logic          o_valid,
    output cbb_pkg::t_vec  o_vc,
    output cbb_pkg::t_side o_side
);
    import cbb_pkg::*;

    // Partial products of a x u
    logic                    r_p_vld;
    logic signed [5:0][63:0] r_p;
    t_side                   r_p_side, n_p_side;

    // Side word picks up the normalized u here
    always_comb begin
        n_p_side   = i_side;
        n_p_side.u = i_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= 64'($signed(i_side.a[1])) * 64'($signed(i_u[2]));
            r_p[1] <= 64'($signed(i_side.a[2])) * 64'($signed(i_u[1]));
            r_p[2] <= 64'($signed(i_side.a[2])) * 64'($signed(i_u[0]));
            r_p[3] <= 64'($signed(i_side.a[0])) * 64'($signed(i_u[2]));
            r_p[4] <= 64'($signed(i_side.a[0])) * 64'($signed(i_u[1]));
            r_p[5] <= 64'($signed(i_side.a[1])) * 64'($signed(i_u[0]));
            r_p_side <= n_p_side;
        end
    end

    // Differences rounded Q60 -> Q30, half away from zero
    logic signed [2:0][63:0] d;
    logic [2:0][63:0]        mag;
    t_vec                    n_vc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i]    = $signed(r_p[2*i]) - $signed(r_p[2*i+1]);
            mag[i]  = d[i][63] ? 64'(-d[i]) : 64'(d[i]);
            mag[i]  = (mag[i] + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
            n_vc[i] = d[i][63] ? -$signed(mag[i][31:0]) : $signed(mag[i][31:0]);
        end
    end

    logic  r_o_vld;
    t_vec  r_o_vc;
    t_side r_o_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_vc   <= n_vc;
            r_o_side <= r_p_side;
        end
    end

    assign o_valid = r_o_vld;
    assign o_vc    = r_o_vc;
    assign o_side  = r_o_side;

endmodule

[rtl/cbb_extent.sv]
module cbb_extent (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cbb_pkg::t_vec    i_v,
    input  cbb_pkg::t_side   i_side,
    input  logic [16:0]     i_bounds_scale,
    input  logic [15:0]     i_pad_fraction,
    input  logic [15:0]     i_min_pad,
    output logic            o_valid,
    output cbb_pkg::t_bounds o_bounds
);
    import cbb_pkg::*;

    // E1: scaled radius/length products, component magnitudes
    logic             r1_vld;
    logic [47:0]      r1_lp, r1_rp;
    logic [2:0][30:0] r1_ma, r1_mu, r1_mv;
    t_vec             r1_ctr;

    logic [30:0] len_pos, rad_pos;
    always_comb begin
        len_pos = (i_side.len > 0) ? i_side.len[30:0] : '0;
        rad_pos = (i_side.rad > 0) ? i_side.rad[30:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lp  <= 48'(len_pos) * 48'(i_bounds_scale);
            r1_rp  <= 48'(rad_pos) * 48'(i_bounds_scale);
            r1_ctr <= i_side.ctr;
            for (int i = 0; i < 3; i++) begin
                r1_ma[i] <= i_side.a[i][31] ? 31'(-i_side.a[i]) : i_side.a[i][30:0];
                r1_mu[i] <= i_side.u[i][31] ? 31'(-i_side.u[i]) : i_side.u[i][30:0];
                r1_mv[i] <= i_v[i][31] ? 31'(-i_v[i]) : i_v[i][30:0];
            end
        end
    end

    // E2: half length and radius rounded
    logic             r2_vld;
    logic [31:0]      r2_hl;
    logic [32:0]      r2_r;
    logic [2:0][30:0] r2_ma, r2_mu, r2_mv;
    t_vec             r2_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_hl  <= 32'((49'(r1_lp) + 49'd65536) >> 17);
            r2_r   <= 33'((49'(r1_rp) + 49'd32768) >> 16);
            r2_ma  <= r1_ma;
            r2_mu  <= r1_mu;
            r2_mv  <= r1_mv;
            r2_ctr <= r1_ctr;
        end
    end

    // E3: extent products, larger of the two sizes
    logic             r3_vld;
    logic [2:0][63:0] r3_pa, r3_pu, r3_pv;
    logic [32:0]      r3_big;
    t_vec             r3_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_pa[i] <= 64'(r2_hl) * 64'(r2_ma[i]);
                r3_pu[i] <= 64'(r2_r) * 64'(r2_mu[i]);
                r3_pv[i] <= 64'(r2_r) * 64'(r2_mv[i]);
            end
            r3_big <= (r2_r > {1'b0, r2_hl}) ? r2_r : {1'b0, r2_hl};
            r3_ctr <= r2_ctr;
        end
    end

    // E4: sum and round extents, padding product
    logic             r4_vld;
    logic [2:0][33:0] r4_e;
    logic [48:0]      r4_pp;
    t_vec             r4_ctr;

    logic [2:0][63:0] s;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i] = r3_pa[i] + r3_pu[i] + r3_pv[i] + (64'd1 << (UNIT_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_e[i] <= s[i][63:UNIT_BITS];
            end
            r4_pp  <= 49'(i_pad_fraction) * 49'(r3_big);
            r4_ctr <= r3_ctr;
        end
    end

    // E5: pad with floor
    logic             r5_vld;
    logic [32:0]      r5_pad;
    logic [2:0][33:0] r5_e;
    t_vec             r5_ctr;

    logic [32:0] padr;
    always_comb begin
        padr = 33'((50'(r4_pp) + 50'd32768) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_pad <= (padr < 33'(i_min_pad)) ? 33'(i_min_pad) : padr;
            r5_e   <= r4_e;
            r5_ctr <= r4_ctr;
        end
    end

    // E6: total half width
    logic             r6_vld;
    logic [2:0][34:0] r6_w;
    t_vec             r6_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_w[i] <= 35'(r5_e[i]) + 35'(r5_pad);
            end
            r6_ctr <= r5_ctr;
        end
    end

    // E7: bounds with saturation
    logic    r7_vld;
    t_bounds r7_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r7_b[2*i]   <= sat32(38'($signed(r6_ctr[i])) - $signed({3'b0, r6_w[i]}));
                r7_b[2*i+1] <= sat32(38'($signed(r6_ctr[i])) + $signed({3'b0, r6_w[i]}));
            end
        end
    end

    assign o_valid  = r7_vld;
    assign o_bounds = r7_b;

endmodule

[rtl/cylinder_bounding_box.sv]
// Padded world-axis bounding box of a finite cylinder. Each input word (center,
// axis of any length, radius, length; signed Q16.16) yields one output word with
// the six bounds, saturated to the signed 32-bit range. The datapath is a fully
// pipelined chain: three vector normalizers (32-stage square root followed by a
// 31-stage divider each), a cross-product stage and a seven-stage extent/pad
// stage. One word enters per clock; the whole pipe advances together and holds
// while a finished word is stalled at the output. Configuration registers are
// always ready and should only be written while the pipeline is empty.
module cylinder_bounding_box (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic [31:0] i_dir_z,
    input  logic [31:0] i_cyl_radius,
    input  logic [31:0] i_cyl_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_x_min,
    output logic [31:0] o_x_max,
    output logic [31:0] o_y_min,
    output logic [31:0] o_y_max,
    output logic [31:0] o_z_min,
    output logic [31:0] o_z_max,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import cbb_pkg::*;

    // Configuration registers
    logic [16:0] r_bounds_scale;
    logic [15:0] r_pad_fraction;
    logic [15:0] r_min_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds_scale <= BOUNDS_SCALE_RST;
            r_pad_fraction <= PAD_FRACTION_RST;
            r_min_pad      <= MIN_PAD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOUNDS_SCALE: r_bounds_scale <= i_cfg_data;
                CFG_PAD_FRACTION: r_pad_fraction <= i_cfg_data[15:0];
                CFG_MIN_PAD:      r_min_pad      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Whole pipe moves unless the output word is stalled
    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // Axis normalize
    t_vec  in_dir;
    t_side in_side;
    always_comb begin
        in_dir     = {i_dir_z, i_dir_y, i_dir_x};
        in_side.ctr = {i_center_z, i_center_y, i_center_x};
        in_side.rad = i_cyl_radius;
        in_side.len = i_cyl_length;
        in_side.a   = '0;
        in_side.u   = '0;
    end

    logic  n1_vld, n1_zero;
    t_vec  n1_vec;
    t_side n1_side;

    cbb_norm u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_vec   (in_dir),
        .i_side  (in_side),
        .o_valid (n1_vld),
        .o_vec   (n1_vec),
        .o_zero  (n1_zero),
        .o_side  (n1_side)
    );

    // Zero axis to +z, reference pick, unnormalized u
    t_vec        a_fix, n_uc;
    logic [30:0] az_mag;
    logic        use_x;
    t_side       n_fx_side;

    always_comb begin
        if (n1_zero) begin
            a_fix = {t_coord'(UNIT_ONE), t_coord'(0), t_coord'(0)};
        end else begin
            a_fix = n1_vec;
        end
        az_mag = a_fix[2][31] ? 31'(-a_fix[2]) : a_fix[2][30:0];
        use_x  = ({az_mag, 3'b0} + {2'b0, az_mag, 1'b0}) > (35'd9 << UNIT_BITS);
        if (use_x) begin
            n_uc = {-a_fix[1], a_fix[2], t_coord'(0)};
        end else begin
            n_uc = {t_coord'(0), -a_fix[0], a_fix[1]};
        end
        n_fx_side   = n1_side;
        n_fx_side.a = a_fix;
    end

    logic  r_fx_vld;
    t_vec  r_fx_uc;
    t_side r_fx_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx_vld <= 1'b0;
        end else if (en) begin
            r_fx_vld <= n1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx_uc   <= n_uc;
            r_fx_side <= n_fx_side;
        end
    end

    // Normalize u
    logic  n2_vld;
    t_vec  n2_vec;
    t_side n2_side;

    cbb_norm u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_fx_vld),
        .i_vec   (r_fx_uc),
        .i_side  (r_fx_side),
        .o_valid (n2_vld),
        .o_vec   (n2_vec),
        .o_zero  (),
        .o_side  (n2_side)
    );

    // v = a x u
    logic  cx_vld;
    t_vec  cx_vc;
    t_side cx_side;

    cbb_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (n2_vld),
        .i_u     (n2_vec),
        .i_side  (n2_side),
        .o_valid (cx_vld),
        .o_vc    (cx_vc),
        .o_side  (cx_side)
    );

    // Normalize v
    logic  n3_vld;
    t_vec  n3_vec;
    t_side n3_side;

    cbb_norm u_norm_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cx_vld),
        .i_vec   (cx_vc),
        .i_side  (cx_side),
        .o_valid (n3_vld),
        .o_vec   (n3_vec),
        .o_zero  (),
        .o_side  (n3_side)
    );

    // Extents, pad and bounds
    t_bounds bounds;

    cbb_extent u_extent (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (n3_vld),
        .i_v            (n3_vec),
        .i_side         (n3_side),
        .i_bounds_scale (r_bounds_scale),
        .i_pad_fraction (r_pad_fraction),
        .i_min_pad      (r_min_pad),
        .o_valid        (o_valid),
        .o_bounds       (bounds)
    );

    assign o_x_min = bounds[0];
    assign o_x_max = bounds[1];
    assign o_y_min = bounds[2];
    assign o_y_max = bounds[3];
    assign o_z_min = bounds[4];
    assign o_z_max = bounds[5];

endmodule

[tb/cylinder_bounding_box_tb.sv]
module cylinder_bounding_box_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbb_pkg::*;

    localparam int PIPE_DEPTH  = 211;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_ITEMS  = 1030;

    // Index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef logic [7:0][31:0] t_cyl_word;   // ctr x/y/z, dir x/y/z, radius, length
    typedef logic [5:0][31:0] t_box_word;   // x_min, x_max, y_min, y_max, z_min, z_max
    typedef longint t_v3 [3];

    // Box predictor plus queue of boxes still owed by the block
    class box_scoreboard;
        logic [16:0] scale;
        logic [15:0] pad_frac;
        logic [15:0] pad_min;
        t_box_word   box_q[$];
        int          n_errors;
        int          n_boxes;

        function new();
            scale    = BOUNDS_SCALE_RST;
            pad_frac = PAD_FRACTION_RST;
            pad_min  = MIN_PAD_RST;
            n_errors = 0;
            n_boxes  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [16:0] data);
            case (idx)
                CFG_BOUNDS_SCALE: scale = data;
                CFG_PAD_FRACTION: pad_frac = data[15:0];
                CFG_MIN_PAD:      pad_min = data[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned mag(longint x);
            return (x < 0) ? longint'(0) - x : x;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // Scale to unit length in Q30, round half away from zero
        function bit unit_q30(t_v3 c, output t_v3 o);
            longint unsigned ss;
            longint unsigned n;
            longint unsigned q;
            ss = 0;
            for (int i = 0; i < 3; i++) ss += mag(c[i]) * mag(c[i]);
            n = int_sqrt(ss);
            if (n == 0) begin
                o = '{0, 0, 0};
                return 0;
            end
            for (int i = 0; i < 3; i++) begin
                q = ((mag(c[i]) << UNIT_BITS) + n / 2) / n;
                o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function longint q60_to_q30(longint x);
            longint unsigned m;
            m = (mag(x) + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
            return (x < 0) ? -longint'(m) : longint'(m);
        endfunction

        function logic [31:0] clamp32(longint x);
            if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (x < -64'sd2147483648) return 32'h8000_0000;
            return x[31:0];
        endfunction

        function t_box_word predict_box(t_cyl_word w);
            t_v3 ctr, dir, ax, uc, u, vc, v;
            longint rad, len;
            longint unsigned half_len, r, big, pad, s, e;
            longint ext;
            t_box_word box;
            for (int i = 0; i < 3; i++) begin
                ctr[i] = longint'($signed(w[i]));
                dir[i] = longint'($signed(w[3 + i]));
            end
            rad = longint'($signed(w[6]));
            len = longint'($signed(w[7]));
            // zero axis falls back to +z
            if (!unit_q30(dir, ax)) ax = '{0, 0, longint'(UNIT_ONE)};
            // near-z axis crosses with x, otherwise with z
            if (10 * mag(ax[2]) > 9 * longint'(UNIT_ONE)) uc = '{0, ax[2], -ax[1]};
            else uc = '{ax[1], -ax[0], 0};
            void'(unit_q30(uc, u));
            vc[0] = q60_to_q30(ax[1] * u[2] - ax[2] * u[1]);
            vc[1] = q60_to_q30(ax[2] * u[0] - ax[0] * u[2]);
            vc[2] = q60_to_q30(ax[0] * u[1] - ax[1] * u[0]);
            void'(unit_q30(vc, v));
            half_len = (len > 0) ? (longint'(len) * scale + (64'd1 << 16)) >> 17 : 0;
            r = (rad > 0) ? (longint'(rad) * scale + (64'd1 << 15)) >> 16 : 0;
            big = (r > half_len) ? r : half_len;
            pad = (pad_frac * big + (64'd1 << 15)) >> 16;
            if (pad < pad_min) pad = pad_min;
            for (int i = 0; i < 3; i++) begin
                s = half_len * mag(ax[i]) + r * mag(u[i]) + r * mag(v[i]);
                e = (s + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
                ext = longint'(e + pad);
                box[2 * i]     = clamp32(ctr[i] - ext);
                box[2 * i + 1] = clamp32(ctr[i] + ext);
            end
            return box;
        endfunction

        function void note_cylinder(t_cyl_word w);
            box_q = {box_q, predict_box(w)};
        endfunction

        function void check_box(t_box_word got);
            t_box_word want;
            string names [6] = '{"x_min", "x_max", "y_min", "y_max", "z_min", "z_max"};
            n_boxes++;
            if (box_q.size() == 0) begin
                $error("box word with nothing expected");
                n_errors++;
                return;
            end
            want = box_q.pop_front();
            for (int i = 0; i < 6; i++) begin
                if (got[i] !== want[i]) begin
                    $error("%s: expected %0d, got %0d", names[i],
                           $signed(want[i]), $signed(got[i]));
                    n_errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [31:0] i_cyl_radius = '0, i_cyl_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_x_min, o_x_max, o_y_min, o_y_max, o_z_min, o_z_max;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    box_scoreboard sb = new();
    int cycles = 0;
    int stall_mode = 0;

    cylinder_bounding_box dut (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stall pattern: free runs, periodic stalls and random stalls
    always @(posedge i_clk) begin
        if (cycles % 512 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ((cycles % 7) < 3);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Monitors for accepted words on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_cylinder({i_cyl_length, i_cyl_radius, i_dir_z, i_dir_y, i_dir_x,
                              i_center_z, i_center_y, i_center_x});
        if (i_rst_n && o_valid && !i_stall)
            sb.check_box({o_z_max, o_z_min, o_y_max, o_y_min, o_x_max, o_x_min});
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            sb.write_reg(i_cfg_index, i_cfg_data);
    end

    int burst_left = 0;

    // Drive one word and hold it until accepted; random gaps between bursts
    task automatic send_cylinder(t_cyl_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_center_x   <= w[0];
        i_center_y   <= w[1];
        i_center_z   <= w[2];
        i_dir_x      <= w[3];
        i_dir_y      <= w[4];
        i_dir_z      <= w[5];
        i_cyl_radius <= w[6];
        i_cyl_length <= w[7];
        do @(posedge i_clk); while (o_stall);
    endtask

    // Let the pipe empty out completely
    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.box_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'd0;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    function automatic t_cyl_word rand_cylinder();
        t_cyl_word w;
        for (int i = 0; i < 8; i++) w[i] = rand_coord();
        case ($urandom_range(0, 5))
            0: w[5:3] = '0;                                     // zero axis
            1: begin                                            // near +/-z axis
                w[3] = $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
                w[4] = $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
                w[5] = ($urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000);
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) begin
            send_cylinder(rand_cylinder());
            // once in a while hold off until the pipe has emptied
            if ($urandom_range(0, 150) == 0) begin
                i_valid <= 1'b0;
                burst_left = 0;
                @(posedge i_clk);
                while (sb.box_q.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    localparam logic [31:0] ZERO = 32'h0000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] NONE = 32'hFFFF_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMAX = 32'h8000_0000;

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases under reset settings
        send_cylinder({ONE, ONE, ONE, ZERO, ZERO, ZERO, ZERO, ZERO});      // basic, +z axis
        send_cylinder({ONE, ONE, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});     // zero axis
        send_cylinder({ONE, ONE, ZERO, ZERO, ONE, ZERO, ZERO, ZERO});      // x axis
        send_cylinder({ONE, ONE, ZERO, ONE, ZERO, ZERO, ZERO, ZERO});      // y axis
        send_cylinder({ONE, ONE, NONE, ZERO, ZERO, ZERO, ZERO, ZERO});     // -z axis
        send_cylinder({ONE, ONE, ONE, ONE, ONE, ZERO, ZERO, ZERO});        // diagonal
        send_cylinder({NONE, NONE, ONE, ZERO, ZERO, ONE, ONE, ONE});       // negative size
        send_cylinder({NMAX, NMAX, ONE, ONE, ONE, ONE, ONE, ONE});
        send_cylinder({PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}); // saturate high
        send_cylinder({PMAX, PMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX}); // saturate low
        send_cylinder({PMAX, ZERO, 32'd1, 32'd0, 32'd0, PMAX, NMAX, ZERO});
        send_cylinder({ZERO, PMAX, 32'd1, 32'd1, 32'd1, ZERO, ZERO, ZERO}); // tiny axis
        send_cylinder({ONE, ONE, 32'd9, 32'd4, ZERO, 32'h5, 32'h6, 32'h7}); // near z threshold
        send_cylinder({ONE, ONE, 32'd9, 32'd5, ZERO, ZERO, ZERO, ZERO});
        send_cylinder({32'd1, 32'd1, ONE, ZERO, ZERO, ZERO, ZERO, ZERO});
        send_cylinder({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_random(RAND_ITEMS / 5);

        // Largest settings; data bit 16 checks masking of the 16-bit registers
        drain_pipe();
        write_cfg(CFG_BOUNDS_SCALE, 17'h1FFFF);
        write_cfg(CFG_PAD_FRACTION, 17'h1FFFF);
        write_cfg(CFG_MIN_PAD, 17'h1FFFF);
        send_random(RAND_ITEMS / 5);

        // Zero scale: box collapses to center plus min pad
        drain_pipe();
        write_cfg(CFG_BOUNDS_SCALE, '0);
        write_cfg(CFG_PAD_FRACTION, '0);
        write_cfg(CFG_MIN_PAD, '0);
        send_cylinder({PMAX, PMAX, ONE, ONE, ONE, ONE, ONE, ONE});
        send_random(RAND_ITEMS / 5);

        // Unused index must be ignored
        drain_pipe();
        write_cfg(CFG_UNUSED, 17'h1FFFF);
        write_cfg(CFG_MIN_PAD, 17'd1);
        send_random(RAND_ITEMS / 5);

        // Random settings across the full register ranges
        drain_pipe();
        write_cfg(CFG_BOUNDS_SCALE, 17'($urandom_range(0, 17'h1FFFF)));
        write_cfg(CFG_PAD_FRACTION, 17'($urandom_range(0, 16'hFFFF)));
        write_cfg(CFG_MIN_PAD, 17'($urandom_range(0, 16'hFFFF)));
        send_random(RAND_ITEMS / 5);

        drain_pipe();
        $display("Checked %0d bounding boxes over five register settings,", sb.n_boxes);
        $display("including zero axes, clamping and random output stalls.");
        if (sb.n_errors == 0 && sb.box_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
